/* src/imu_read_transfer_scheduler_defines.svh */
// assertion macros for the imu read transfer scheduler checker
// no dependencies
`ifndef IMU_READ_TRANSFER_SCHEDULER_DEFINES_SVH
`define IMU_READ_TRANSFER_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define IRTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("irts check failed");

// next-cycle implication, disabled while in reset
`define IRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("irts check failed");

`endif

/* src/irts_pkg.sv */
// shared types and constants of the imu read transfer scheduler
// no dependencies
`timescale 1ns / 1ps

package irts_pkg;

	// event codes
	typedef enum logic [2:0] {
		ACT_FAST_TICK = 3'd0,
		ACT_SLOW_TICK = 3'd1,
		ACT_ACCEL_RDY = 3'd2,
		ACT_GYRO_RDY  = 3'd3,
		ACT_DONE      = 3'd4
	} action_t;

	// read codes, used for request and in_flight
	localparam logic [1:0] REQ_NONE  = 2'd0;
	localparam logic [1:0] REQ_ACCEL = 2'd1;
	localparam logic [1:0] REQ_GYRO  = 2'd2;
	localparam logic [1:0] REQ_TEMP  = 2'd3;

	// channel bit positions
	localparam int CH_ACCEL = 0;
	localparam int CH_GYRO  = 1;
	localparam int CH_TEMP  = 2;

	// completion device
	localparam logic DEV_ACCEL = 1'b0;

	// register indexes
	localparam logic [2:0] REG_ENABLE      = 3'd0;
	localparam logic [2:0] REG_TEMP_PERIOD = 3'd1;
	localparam logic [2:0] REG_TIMEOUT     = 3'd2;
	localparam logic [2:0] REG_ACCEL_ADDR  = 3'd3;
	localparam logic [2:0] REG_TEMP_ADDR   = 3'd4;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// reset values of the registers
	localparam logic [15:0] TEMP_PERIOD_RST = 16'd128;
	localparam logic [15:0] TIMEOUT_RST     = 16'd2;
	localparam logic [6:0]  ACCEL_ADDR_RST  = 7'd18;
	localparam logic [6:0]  TEMP_ADDR_RST   = 7'd34;

	// expected lengths of good transfers
	localparam logic [7:0] ACCEL_DATA_LEN = 8'd6;
	localparam logic [7:0] TEMP_DATA_LEN  = 8'd2;

	typedef struct packed {
		logic [2:0] action;
		logic       bus_accepts;
		logic       done_device;
		logic [6:0] done_address;
		logic [7:0] done_length;
	} evt_t;

	typedef struct packed {
		logic [1:0] request;
		logic       retry;
		logic [1:0] in_flight;
	} res_t;

endpackage

/* src/irts_chan_if.sv */
// valid/ready channel carrying one request of a given payload type
// payload types come from irts_pkg
`timescale 1ns / 1ps

interface irts_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/imu_read_transfer_scheduler.sv */
// imu read transfer scheduler, top level; uses irts_pkg and irts_chan_if
// an accepted event is held in the event register, then moves into the result register
// throughput: one event per cycle while results are taken; a stalled result
// still lets one more event into the event register before the input side stalls
// reset: arst_n clears all flags, counters and valid bits asynchronously and
// loads the configuration registers with their default values
`timescale 1ns / 1ps

module imu_read_transfer_scheduler #(
	parameter int TICK_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	irts_chan_if.sink                   events,
	irts_chan_if.source                 results,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irts_pkg::PADDR_W-1:0] paddr,
	input  logic [irts_pkg::PDATA_W-1:0] pwdata,
	output logic [irts_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);

	// elapsed time is compared against a 16-bit timeout, so widen to whichever is larger
	localparam int CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

	// configuration registers
	logic        enable_q;
	logic [15:0] temp_period_q;
	logic [15:0] timeout_q;
	logic [6:0]  accel_addr_q;
	logic [6:0]  temp_addr_q;

	// scheduler state; bit order of the flag vectors is accel, gyro, temperature
	logic [TICK_WIDTH-1:0] tick_q;
	logic [2:0]            pend_q;
	logic [2:0]            busy_q;
	logic [TICK_WIDTH-1:0] start_q [3];
	logic [15:0]           slow_q;

	// event register and result register
	irts_pkg::evt_t item_s1;
	logic           valid_s1;
	irts_pkg::res_t res_q;
	logic           res_valid_q;

	logic advance;

	// next-state values
	logic [TICK_WIDTH-1:0] tick_nx;
	logic [2:0]            pend_nx;
	logic [2:0]            busy_nx;
	logic [2:0]            start_we;
	logic [15:0]           slow_nx;
	irts_pkg::res_t        res_nx;

	// decode helpers
	logic [TICK_WIDTH-1:0] tick_inc;
	logic [TICK_WIDTH-1:0] elapsed [3];
	logic [2:0]            timed_out;
	logic [2:0]            cand;
	logic [2:0]            sel;
	logic                  is_retry;
	logic [15:0]           slow_inc;
	logic                  cfg_wr;

	//------------------------------------------------------------------
	// configuration port: writes complete in the access phase, no wait states
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b0;
			temp_period_q <= irts_pkg::TEMP_PERIOD_RST;
			timeout_q     <= irts_pkg::TIMEOUT_RST;
			accel_addr_q  <= irts_pkg::ACCEL_ADDR_RST;
			temp_addr_q   <= irts_pkg::TEMP_ADDR_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				irts_pkg::REG_ENABLE:      enable_q      <= pwdata[0];
				irts_pkg::REG_TEMP_PERIOD: temp_period_q <= pwdata[15:0];
				irts_pkg::REG_TIMEOUT:     timeout_q     <= pwdata[15:0];
				irts_pkg::REG_ACCEL_ADDR:  accel_addr_q  <= pwdata[6:0];
				irts_pkg::REG_TEMP_ADDR:   temp_addr_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// read-back mux
	always_comb begin
		case (paddr[4:2])
			irts_pkg::REG_ENABLE:      prdata = {31'd0, enable_q};
			irts_pkg::REG_TEMP_PERIOD: prdata = {16'd0, temp_period_q};
			irts_pkg::REG_TIMEOUT:     prdata = {16'd0, timeout_q};
			irts_pkg::REG_ACCEL_ADDR:  prdata = {25'd0, accel_addr_q};
			irts_pkg::REG_TEMP_ADDR:   prdata = {25'd0, temp_addr_q};
			default:                   prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// handshake: the registered event moves on whenever the result slot is
	// free or being emptied; a new event enters when the event register
	// is empty or moving on in the same cycle
	//------------------------------------------------------------------
	assign advance      = valid_s1 && (!res_valid_q || results.ready);
	assign events.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			item_s1 <= events.data;
		end
	end

	//------------------------------------------------------------------
	// scheduling decision for the registered event
	//------------------------------------------------------------------
	assign tick_inc = tick_q + 1'b1;
	assign slow_inc = slow_q + 16'd1;

	// timeout check uses the tick count after this tick's increment;
	// the subtraction wraps at the tick width
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			elapsed[i]   = tick_inc - start_q[i];
			timed_out[i] = busy_q[i] && (CMP_W'(elapsed[i]) >= CMP_W'(timeout_q));
		end
	end

	// a fresh start takes precedence and needs an idle bus; else a timed-out retry
	always_comb begin
		if ((busy_q == 3'b000) && (pend_q != 3'b000)) begin
			cand     = pend_q;
			is_retry = 1'b0;
		end else begin
			cand     = timed_out;
			is_retry = timed_out != 3'b000;
		end
		// lowest set bit wins: accel, then gyro, then temperature
		sel = cand & (~cand + 3'd1);
	end

	always_comb begin
		tick_nx          = tick_q;
		pend_nx          = pend_q;
		busy_nx          = busy_q;
		start_we         = 3'b000;
		slow_nx          = slow_q;
		res_nx.request   = irts_pkg::REQ_NONE;
		res_nx.retry     = 1'b0;

		if (enable_q) begin
			case (item_s1.action)
				irts_pkg::ACT_FAST_TICK: begin
					tick_nx = tick_inc;
					if (sel != 3'b000) begin
						res_nx.retry = is_retry;
						// refused reads fall back to pending and leave the bus free
						if (item_s1.bus_accepts) begin
							busy_nx  = busy_q | sel;
							pend_nx  = pend_q & ~sel;
							start_we = sel;
						end else begin
							busy_nx = busy_q & ~sel;
							pend_nx = pend_q | sel;
						end
					end
					priority if (sel[irts_pkg::CH_ACCEL]) begin
						res_nx.request = irts_pkg::REQ_ACCEL;
					end else if (sel[irts_pkg::CH_GYRO]) begin
						res_nx.request = irts_pkg::REQ_GYRO;
					end else if (sel[irts_pkg::CH_TEMP]) begin
						res_nx.request = irts_pkg::REQ_TEMP;
					end else begin
						res_nx.request = irts_pkg::REQ_NONE;
					end
				end
				irts_pkg::ACT_SLOW_TICK: begin
					// period reached: restart the count and ask for a temperature read
					if (slow_inc >= temp_period_q) begin
						slow_nx                   = 16'd0;
						pend_nx[irts_pkg::CH_TEMP] = 1'b1;
					end else begin
						slow_nx = slow_inc;
					end
				end
				irts_pkg::ACT_ACCEL_RDY: begin
					pend_nx[irts_pkg::CH_ACCEL] = 1'b1;
				end
				irts_pkg::ACT_GYRO_RDY: begin
					pend_nx[irts_pkg::CH_GYRO] = 1'b1;
				end
				irts_pkg::ACT_DONE: begin
					// accel chip completions are matched on address and length;
					// a mismatch leaves the transfer outstanding
					if (item_s1.done_device == irts_pkg::DEV_ACCEL) begin
						if ((item_s1.done_address == accel_addr_q) &&
							(item_s1.done_length == irts_pkg::ACCEL_DATA_LEN)) begin
							busy_nx[irts_pkg::CH_ACCEL] = 1'b0;
							pend_nx[irts_pkg::CH_ACCEL] = 1'b1;
						end else if ((item_s1.done_address == temp_addr_q) &&
							(item_s1.done_length == irts_pkg::TEMP_DATA_LEN)) begin
							busy_nx[irts_pkg::CH_TEMP] = 1'b0;
						end
					end else begin
						busy_nx[irts_pkg::CH_GYRO] = 1'b0;
						pend_nx[irts_pkg::CH_GYRO] = 1'b1;
					end
				end
				default: ;
			endcase
		end

		// outstanding read after this event, accel first
		priority if (busy_nx[irts_pkg::CH_ACCEL]) begin
			res_nx.in_flight = irts_pkg::REQ_ACCEL;
		end else if (busy_nx[irts_pkg::CH_GYRO]) begin
			res_nx.in_flight = irts_pkg::REQ_GYRO;
		end else if (busy_nx[irts_pkg::CH_TEMP]) begin
			res_nx.in_flight = irts_pkg::REQ_TEMP;
		end else begin
			res_nx.in_flight = irts_pkg::REQ_NONE;
		end
	end

	//------------------------------------------------------------------
	// state update, only when the event moves into the result register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			pend_q <= 3'b000;
			busy_q <= 3'b000;
			slow_q <= 16'd0;
		end else if (advance) begin
			tick_q <= tick_nx;
			pend_q <= pend_nx;
			busy_q <= busy_nx;
			slow_q <= slow_nx;
		end
	end

	// start stamps are only looked at while the matching busy flag is set
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (advance && start_we[i]) begin
				start_q[i] <= tick_nx;
			end
		end
	end

	//------------------------------------------------------------------
	// result register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign results.valid = res_valid_q;
	assign results.data  = res_q;

endmodule

/* src/irts_checker.sv */
// port-level checks for the imu read transfer scheduler, bound to the top level
// uses irts_pkg and imu_read_transfer_scheduler_defines.svh
`timescale 1ns / 1ps
`include "imu_read_transfer_scheduler_defines.svh"

module irts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           res_valid,
	input logic           res_ready,
	input irts_pkg::res_t res_data,
	input logic           pready
);

	// a stalled result holds its value
	`IRTS_ASSERT_NEXT(res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_data))

	// retry only comes with an attempted read
	`IRTS_ASSERT_IMPLY(retry_needs_req, clk, arst_n, res_valid && res_data.retry, res_data.request != irts_pkg::REQ_NONE)

	// after an attempt, either that read is outstanding or nothing is
	`IRTS_ASSERT_IMPLY(req_flight_match, clk, arst_n, res_valid && (res_data.request != irts_pkg::REQ_NONE), (res_data.in_flight == res_data.request) || (res_data.in_flight == irts_pkg::REQ_NONE))

	// configuration port never inserts wait states
	`IRTS_ASSERT_IMPLY(no_wait, clk, arst_n, 1'b1, pready)

endmodule

bind imu_read_transfer_scheduler irts_checker u_irts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_data  (results.data),
	.pready    (pready)
);
